// ----- sv/flow_table_accumulator_unit_macros.svh -----
// Assertion macros for the flow table accumulator checker
`ifndef FLOW_TABLE_ACCUMULATOR_UNIT_MACROS_SVH
`define FLOW_TABLE_ACCUMULATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define FTACC_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("flow table accumulator check failed");

// Next-cycle implication, sampled on clk, off while rst is high
`define FTACC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("flow table accumulator check failed");

`endif

// ----- sv/ftacc_pkg.sv -----
// Shared types and constants for the flow table accumulator
package ftacc_pkg;

  localparam int TABLE_SIZE_DEF = 128;
  localparam int ADDR_W         = 32;
  localparam int PORT_W         = 16;
  localparam int SUM_W          = 32;
  localparam int SLOT_W         = 7;
  localparam int DIGIT_W        = 8;
  localparam int DIGITS         = ADDR_W / DIGIT_W;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_NEW  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic clr_wr;
    logic load_key;
    logic hash_step;
    logic home;
    logic rd;
    logic advance;
    logic commit;
  } ftacc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hash_last;
    logic hit;
    logic free;
    logic probe_last;
    logic out_free;
  } ftacc_sts_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [SUM_W-1:0]  sum;
  } entry_t;

endpackage

// ----- sv/ftacc_ctrl.sv -----
// Control state machine: clearing pass, hashing, probing and commit
module ftacc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ftacc_pkg::ftacc_sts_t  sts,
  output ftacc_pkg::ftacc_cmd_t  cmd
);
  import ftacc_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_HOME  = 6'b001000,
    S_READ  = 6'b010000,
    S_CHECK = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_key = 1'b1;
          state_next   = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_last) state_next = S_HOME;
      end
      S_HOME: begin
        // first probe is read at the home slot
        cmd.home   = 1'b1;
        state_next = S_CHECK;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.hit || sts.free || sts.probe_last) begin
          // hold the decision until the output register can take it
          if (sts.out_free) begin
            cmd.commit = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- sv/ftacc_dpath.sv -----
// Datapath: key registers, home-slot hash, entry memory and output register
module ftacc_dpath #(
  parameter int TABLE_SIZE = ftacc_pkg::TABLE_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [ftacc_pkg::ADDR_W-1:0]      src_addr,
  input  logic [ftacc_pkg::PORT_W-1:0]      src_port,
  input  logic signed [ftacc_pkg::SUM_W-1:0] value,
  input  ftacc_pkg::ftacc_cmd_t             cmd,
  output ftacc_pkg::ftacc_sts_t             sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ftacc_pkg::SLOT_W-1:0]      slot,
  output logic [1:0]                        status,
  output logic signed [ftacc_pkg::SUM_W-1:0] flow_sum
);
  import ftacc_pkg::*;

  localparam int               IDX_W    = $clog2(TABLE_SIZE);
  localparam int               DIG_CW   = $clog2(DIGITS);
  localparam logic [IDX_W:0]   MOD_C    = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  logic [ADDR_W-1:0] key_addr;
  logic [PORT_W-1:0] key_port;
  logic [SUM_W-1:0]  key_val;
  logic [ADDR_W-1:0] word_q;
  logic [DIG_CW-1:0] dig_cnt;
  logic [IDX_W-1:0]  rem_q;
  logic [IDX_W-1:0]  rem_step;
  logic [IDX_W-1:0]  home;
  logic [IDX_W:0]    home_sum;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  probe_cnt;
  logic [IDX_W-1:0]  clr_idx;

  entry_t            mem [TABLE_SIZE];
  entry_t            rd_q;
  entry_t            wr_data;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_en;
  logic              hit_c;
  logic              free_c;
  logic [SUM_W-1:0]  new_sum;
  logic [SLOT_W+IDX_W-1:0] slot_ext;

  status_t           status_q;

  // remainder of the key word, eight bits per cycle, msb first
  always_comb begin : hash_digit
    logic [IDX_W:0]   t;
    logic [IDX_W-1:0] r;
    r = rem_q;
    for (int j = 0; j < DIGIT_W; j++) begin
      t = {r, word_q[ADDR_W-1-j]};
      if (t >= MOD_C) t = t - MOD_C;
      r = t[IDX_W-1:0];
    end
    rem_step = r;
  end

  // the +1 of the hash folds in after the remainder
  always_comb begin
    home_sum = {1'b0, rem_q} + (IDX_W + 1)'(1);
    if (home_sum >= MOD_C) home_sum = home_sum - MOD_C;
    home = home_sum[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_addr <= src_addr;
      key_port <= src_port;
      key_val  <= value;
      word_q   <= {src_addr[ADDR_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
                  | {{(ADDR_W-PORT_W){1'b0}}, src_port};
      rem_q    <= '0;
      dig_cnt  <= '0;
    end else if (cmd.hash_step) begin
      rem_q   <= rem_step;
      word_q  <= word_q << DIGIT_W;
      dig_cnt <= dig_cnt + DIG_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.home) begin
      idx       <= home;
      probe_cnt <= '0;
    end else if (cmd.advance) begin
      idx       <= (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
      probe_cnt <= probe_cnt + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_wr) begin
      clr_idx <= (clr_idx == LAST_IDX) ? '0 : clr_idx + IDX_W'(1);
    end
  end

  // entry memory: one write port, one registered read port
  assign rd_addr = cmd.home ? home : idx;
  assign hit_c   = rd_q.valid && (rd_q.addr == key_addr) && (rd_q.port == key_port);
  assign free_c  = !rd_q.valid;
  assign new_sum = hit_c ? rd_q.sum + key_val : key_val;
  assign wr_en   = cmd.clr_wr || (cmd.commit && (hit_c || free_c));
  assign wr_addr = cmd.clr_wr ? clr_idx : idx;

  always_comb begin
    if (cmd.clr_wr) begin
      wr_data = '0;
    end else begin
      wr_data.valid = 1'b1;
      wr_data.addr  = key_addr;
      wr_data.port  = key_port;
      wr_data.sum   = new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.home || cmd.rd) rd_q <= mem[rd_addr];
  end

  assign slot_ext = {{SLOT_W{1'b0}}, idx};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (hit_c) begin
        status_q <= ST_HIT;
      end else if (free_c) begin
        status_q <= ST_NEW;
      end else begin
        status_q <= ST_FULL;
      end
      slot     <= (hit_c || free_c) ? slot_ext[SLOT_W-1:0] : '0;
      flow_sum <= (hit_c || free_c) ? new_sum : '0;
    end
  end

  assign status = status_q;

  always_comb begin
    sts.clr_last   = (clr_idx == LAST_IDX);
    sts.hash_last  = (dig_cnt == DIG_CW'(DIGITS - 1));
    sts.hit        = hit_c;
    sts.free       = free_c;
    sts.probe_last = (probe_cnt == LAST_IDX);
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

// ----- sv/flow_table_accumulator_unit.sv -----
// After an input transfer the key is hashed one eight-bit digit at a time into the home slot;
//   the probe loop then does one memory read and compare per slot, from the home slot on,
//   until a hit, a free slot or the last slot. A new item is taken only once the last commits.
// A full table probes every slot.
// Reset: synchronous; a clearing pass then writes every entry invalid, with in_ready
//   low until it ends.
module flow_table_accumulator_unit #(
  parameter int TABLE_SIZE = ftacc_pkg::TABLE_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ftacc_pkg::ADDR_W-1:0]       src_addr,
  input  logic [ftacc_pkg::PORT_W-1:0]       src_port,
  input  logic signed [ftacc_pkg::SUM_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ftacc_pkg::SLOT_W-1:0]       slot,
  output logic [1:0]                         status,
  output logic signed [ftacc_pkg::SUM_W-1:0] flow_sum
);
  import ftacc_pkg::*;

  ftacc_cmd_t cmd;
  ftacc_sts_t sts;

  ftacc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ftacc_dpath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .src_addr  (src_addr),
    .src_port  (src_port),
    .value     (value),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .slot      (slot),
    .status    (status),
    .flow_sum  (flow_sum)
  );

endmodule

// ----- sv/ftacc_checker.sv -----
// Port-level checker for the flow table accumulator, bound to the top level
`include "flow_table_accumulator_unit_macros.svh"

module ftacc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [ftacc_pkg::SLOT_W-1:0]       slot,
  input logic [1:0]                         status,
  input logic signed [ftacc_pkg::SUM_W-1:0] flow_sum
);
  import ftacc_pkg::*;

  // a dropped item reports slot zero and a zero sum
  `FTACC_ASSERT_SAME(a_full_zero, out_valid && (status == ST_FULL), (slot == '0) && (flow_sum == '0))

  // one item in flight: no second transfer right after the first
  `FTACC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // hashing alone takes cycles, so no result appears the cycle after a transfer
  `FTACC_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid))

  // a stalled result holds
  `FTACC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(slot) && $stable(status) && $stable(flow_sum))

endmodule

bind flow_table_accumulator_unit ftacc_checker u_ftacc_checker (.*);
